// ===== design/mrfr_pkg.sv =====
`default_nettype none

package mrfr_pkg;

  localparam int unsigned MaxFrameDefault = 256;

  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'hA001;
  localparam logic [8:0]  CountSat = 9'd256;
  localparam logic [16:0] TickSat  = 17'h0FFFF;

  localparam logic [7:0]  OwnAddrReset   = 8'd1;
  localparam logic [15:0] SilenceReset   = 16'd3;
  localparam logic [15:0] ReplyDelReset  = 16'd10;
  localparam logic [15:0] DelayStepReset = 16'd1;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_BYTE    = 2'd1,
    ACT_TX_DONE = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    EV_ACCEPTED   = 3'd0,
    EV_WRONG_ADDR = 3'd1,
    EV_BAD_CRC    = 3'd2,
    EV_TOO_LONG   = 3'd3,
    EV_REPLY_DUE  = 3'd4
  } event_e;

  typedef enum logic [1:0] {
    PH_RECEIVING = 2'd0,
    PH_DELAYING  = 2'd1,
    PH_WAIT_TX   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    CFG_OWN_ADDR   = 2'd0,
    CFG_SILENCE    = 2'd1,
    CFG_REPLY_DEL  = 2'd2,
    CFG_DELAY_STEP = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [8:0] frame_length;
  } out_item_t;

  // item held in the input register, as seen by the frame controller
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } step_t;

  // result offered by the frame controller to the output register
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

  // CRC-16/MODBUS, one byte, reflected
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/mrfr_in_stage.sv =====
`default_nettype none

module mrfr_in_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire mrfr_pkg::in_item_t in_item_i,
  input  wire logic              pop_i,
  output mrfr_pkg::step_t        step_o
);

  logic               valid_q, valid_d;
  mrfr_pkg::in_item_t item_q;

  assign in_ready_o = !valid_q || pop_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign step_o.valid = valid_q;
  assign step_o.item  = item_q;

endmodule

`default_nettype wire

// ===== design/mrfr_frame_ctrl.sv =====
`default_nettype none

module mrfr_frame_ctrl #(
  parameter int unsigned MaxFrame = mrfr_pkg::MaxFrameDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_idx_i,
  input  wire logic [15:0]     cfg_data_i,
  input  wire mrfr_pkg::step_t step_i,
  input  wire logic            adv_i,
  output mrfr_pkg::res_t       res_o
);

  localparam logic [8:0] MaxCount = 9'(MaxFrame);

  logic [7:0]  own_addr_q;
  logic [15:0] silence_q, reply_del_q, delay_step_q;

  mrfr_pkg::phase_e phase_q, phase_d;
  logic [8:0]  cnt_q, cnt_d;
  logic        ovf_q, ovf_d;
  logic [7:0]  first_q, first_d;
  logic [15:0] crc_q, crc_d;
  logic [16:0] tick_q, tick_d;
  logic [16:0] tick_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q   <= mrfr_pkg::OwnAddrReset;
      silence_q    <= mrfr_pkg::SilenceReset;
      reply_del_q  <= mrfr_pkg::ReplyDelReset;
      delay_step_q <= mrfr_pkg::DelayStepReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mrfr_pkg::CFG_OWN_ADDR:   own_addr_q   <= cfg_data_i[7:0];
        mrfr_pkg::CFG_SILENCE:    silence_q    <= cfg_data_i;
        mrfr_pkg::CFG_REPLY_DEL:  reply_del_q  <= cfg_data_i;
        mrfr_pkg::CFG_DELAY_STEP: delay_step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign tick_inc = (tick_q < mrfr_pkg::TickSat) ? tick_q + 17'd1 : tick_q;

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    first_d   = first_q;
    crc_d     = crc_q;
    tick_d    = tick_q;
    res_o     = '0;
    if (adv_i && step_i.valid) begin
      case (phase_q)
        mrfr_pkg::PH_RECEIVING: begin
          if (step_i.item.action == mrfr_pkg::ACT_BYTE) begin
            if (cnt_q == 9'd0) begin
              first_d = step_i.item.rx_byte;
            end
            if (cnt_q >= MaxCount) begin
              ovf_d = 1'b1;
            end
            if (cnt_q < mrfr_pkg::CountSat) begin
              cnt_d = cnt_q + 9'd1;
            end
            crc_d  = mrfr_pkg::crc_byte(crc_q, step_i.item.rx_byte);
            tick_d = '0;
          end else if (step_i.item.action == mrfr_pkg::ACT_TICK && cnt_q != 9'd0) begin
            if (tick_inc < {1'b0, silence_q}) begin
              tick_d = tick_inc;
            end else begin
              // frame ended: judge it and start over
              res_o.valid             = 1'b1;
              res_o.item.frame_length = cnt_q;
              if (ovf_q) begin
                res_o.item.event_res = mrfr_pkg::EV_TOO_LONG;
              end else if (first_q != own_addr_q) begin
                res_o.item.event_res = mrfr_pkg::EV_WRONG_ADDR;
              end else if (cnt_q < 9'd4 || crc_q != 16'd0) begin
                res_o.item.event_res = mrfr_pkg::EV_BAD_CRC;
              end else begin
                res_o.item.event_res = mrfr_pkg::EV_ACCEPTED;
                phase_d              = mrfr_pkg::PH_DELAYING;
              end
              cnt_d   = '0;
              ovf_d   = 1'b0;
              first_d = '0;
              crc_d   = mrfr_pkg::CrcInit;
              tick_d  = '0;
            end
          end
        end
        mrfr_pkg::PH_DELAYING: begin
          if (step_i.item.action == mrfr_pkg::ACT_TICK) begin
            if (tick_q <= {1'b0, reply_del_q}) begin
              // never wraps: tick_q stays within 16 bits here
              tick_d = tick_q + {1'b0, delay_step_q};
            end else begin
              tick_d                  = '0;
              phase_d                 = mrfr_pkg::PH_WAIT_TX;
              res_o.valid             = 1'b1;
              res_o.item.event_res    = mrfr_pkg::EV_REPLY_DUE;
              res_o.item.frame_length = '0;
            end
          end
        end
        mrfr_pkg::PH_WAIT_TX: begin
          if (step_i.item.action == mrfr_pkg::ACT_TX_DONE) begin
            phase_d = mrfr_pkg::PH_RECEIVING;
            cnt_d   = '0;
            ovf_d   = 1'b0;
            first_d = '0;
            crc_d   = mrfr_pkg::CrcInit;
            tick_d  = '0;
          end
        end
        default: begin
          phase_d = mrfr_pkg::PH_RECEIVING;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mrfr_pkg::PH_RECEIVING;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      first_q <= '0;
      crc_q   <= mrfr_pkg::CrcInit;
      tick_q  <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      first_q <= first_d;
      crc_q   <= crc_d;
      tick_q  <= tick_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/mrfr_out_stage.sv =====
`default_nettype none

module mrfr_out_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire mrfr_pkg::res_t res_i,
  input  wire logic           adv_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output mrfr_pkg::out_item_t out_item_o
);

  logic                valid_q, valid_d;
  logic                load;
  mrfr_pkg::out_item_t item_q;

  assign free_o = !valid_q || out_ready_i;
  assign load   = adv_i && res_i.valid;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= res_i.item;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

`default_nettype wire

// ===== design/modbus_rtu_frame_receiver.sv =====
// Modbus RTU server link layer: frame end detection, address and CRC check,
// reply timing.
// Input channel (in_valid_i/in_ready_o, in_item_i): one item per accept, a
//   timer tick, a received byte or a transmit-done event.
// Output channel (out_valid_o/out_ready_i, out_item_o): zero or one result per
//   input item: frame accepted, wrong address, bad CRC or short, too long,
//   or reply due (frame_length 0 for reply due).
// Config port: cfg_we_i writes cfg_data_i into the register cfg_idx_i
//   (0 own address, 1 silence ticks, 2 reply delay, 3 delay step) at once.
// Path: an item is held in the input register and judged into the output
//   register, which holds its result; a full, untaken output register holds it back.
// Throughput: one item per cycle unless the output stalls; all frame state updates
//   together, the CRC byte update being one unrolled eight-bit step.
// Stall: when the output register holds an untaken result, the input
//   register still moves on as soon as out_ready_i is high; with out_ready_i
//   low and a result pending, in_ready_o drops after the input register fills.
// Reset: both stages empty, state receiving, CRC 0xFFFF, registers back to
//   address 1, silence 3, reply delay 10, delay step 1.
`default_nettype none

module modbus_rtu_frame_receiver #(
  parameter int unsigned MaxFrame = mrfr_pkg::MaxFrameDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire mrfr_pkg::in_item_t in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output mrfr_pkg::out_item_t     out_item_o,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [15:0]        cfg_data_i
);

  mrfr_pkg::step_t step;
  mrfr_pkg::res_t  res;
  logic            out_free;
  logic            adv;

  assign adv = step.valid && out_free;

  mrfr_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .pop_i      (adv),
    .step_o     (step)
  );

  mrfr_frame_ctrl #(
    .MaxFrame (MaxFrame)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (step),
    .adv_i      (adv),
    .res_o      (res)
  );

  mrfr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .adv_i       (adv),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ===== design/mrfr_checker.sv =====
`default_nettype none

module mrfr_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire mrfr_pkg::out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output item changed while stalled");

  a_reply_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.event_res == mrfr_pkg::EV_REPLY_DUE
      |-> out_item_o.frame_length == 9'd0)
    else $error("reply due carries a frame length");

  a_frame_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.event_res != mrfr_pkg::EV_REPLY_DUE
      |-> out_item_o.frame_length != 9'd0 && out_item_o.frame_length <= 9'd256)
    else $error("frame verdict with impossible length");

  a_short_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.event_res == mrfr_pkg::EV_ACCEPTED
      |-> out_item_o.frame_length >= 9'd4)
    else $error("short frame accepted");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result present right after reset");

endmodule

bind modbus_rtu_frame_receiver mrfr_checker u_mrfr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
